[src/sld_pkg.sv]
package sld_pkg;

  // fixed field widths
  localparam int DELTA_W   = 32;
  localparam int REG_W     = 32;
  localparam int DENSITY_W = 40;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 64;

  // default parameter values
  localparam int TYPE_COUNT_DEF    = 2;
  localparam int FRACTION_BITS_DEF = 16;

  // kernel arithmetic
  localparam int GUARD_BITS = 23;
  localparam int X_W        = 63;
  localparam logic [REG_W-1:0] KERNEL_CONST = 32'd2242948560;
  localparam logic [DENSITY_W-1:0] DENSITY_MAX = {DENSITY_W{1'b1}};
  localparam logic [REG_W-1:0] REG_RESET_ONE = 32'h0001_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUT_AA = 3'd0,
    CFG_CUT_AB = 3'd1,
    CFG_CUT_BB = 3'd2,
    CFG_MASS_A = 3'd3,
    CFG_MASS_B = 3'd4
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SQZ,
    ST_HH,
    ST_CMP,
    ST_SQRT,
    ST_TGO,
    ST_TWAIT,
    ST_SGO,
    ST_SWAIT,
    ST_MT2,
    ST_MT3,
    ST_MP,
    ST_MK,
    ST_MM,
    ST_XLOAD,
    ST_XGO,
    ST_XWAIT,
    ST_ACC,
    ST_FIN
  } state_t;

endpackage

[src/sld_if.sv]
interface sld_in_if;
  import sld_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DELTA_W-1:0] delta_x;
  logic signed [DELTA_W-1:0] delta_y;
  logic signed [DELTA_W-1:0] delta_z;
  logic                      center_type;
  logic                      neighbor_type;
  logic                      pair_valid;
  logic                      last_neighbor;
  modport source (output valid, delta_x, delta_y, delta_z, center_type, neighbor_type,
                  pair_valid, last_neighbor, input ready);
  modport sink (input valid, delta_x, delta_y, delta_z, center_type, neighbor_type,
                pair_valid, last_neighbor, output ready);
endinterface

interface sld_out_if;
  import sld_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [DENSITY_W-1:0] density;
  logic                 density_saturated;
  modport source (output valid, density, density_saturated, input ready);
  modport sink (input valid, density, density_saturated, output ready);
endinterface

interface sld_cfg_if;
  import sld_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[src/sld_div.sv]
module sld_div import sld_pkg::*; #(
  parameter int DW = 80
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DW-1:0]    dividend,
  input  logic [REG_W-1:0] divisor,
  output logic             done,
  output logic [DW-1:0]    quot
);

  localparam int CNT_W = $clog2(DW);

  logic [DW-1:0]    quot_r, quot_nxt;
  logic [REG_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [REG_W:0]   rem_sh;
  logic [REG_W:0]   rem_diff;

  // one restoring step per cycle
  always_comb begin
    rem_sh   = {rem_r, quot_r[DW-1]};
    rem_diff = rem_sh - {1'b0, divisor};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt  = rem_diff[REG_W-1:0];
        quot_nxt = {quot_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[REG_W-1:0];
        quot_nxt = {quot_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

[src/sld_sqrt.sv]
module sld_sqrt import sld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [PROD_W-1:0] radicand,
  output logic              done,
  output logic [REG_W-1:0]  root
);

  localparam int CNT_W = $clog2(REG_W);

  logic [PROD_W-1:0] rad_r, rad_nxt;
  logic [REG_W+1:0]  rem_r, rem_nxt;
  logic [REG_W-1:0]  root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [REG_W+3:0]  rem_sh;
  logic [REG_W+3:0]  trial;
  logic [REG_W+3:0]  rem_diff;

  // one result bit per cycle, two radicand bits in
  always_comb begin
    rem_sh   = {rem_r, rad_r[PROD_W-1:PROD_W-2]};
    trial    = {2'b00, root_r, 2'b01};
    rem_diff = rem_sh - trial;
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[PROD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_diff[REG_W+1:0];
        root_nxt = {root_r[REG_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[REG_W+1:0];
        root_nxt = {root_r[REG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(REG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

[src/sph_lucy_density_sum_top.sv]
// channel   | dir | handshake    | payload
// in_pair   | in  | valid/ready  | delta_x/y/z, center_type, neighbor_type, pair_valid,
//           |     |              | last_neighbor
// out_dens  | out | valid/ready  | density, density_saturated
// cfg_wr    | in  | valid/ready  | index, data (always ready)
//
// one request at a time: a pair outside the cutoff skips the arithmetic, while a pair inside
// runs the bit-serial divider five times per pair plus the 32-step square root
// the result sits in an output register, so the next pair is taken while it waits
// rst_n is synchronous; it restores the register defaults and clears the density sum
module sph_lucy_density_sum_top import sld_pkg::*; #(
  parameter int TYPE_COUNT    = TYPE_COUNT_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  sld_in_if.sink      in_pair,
  sld_out_if.source   out_dens,
  sld_cfg_if.sink     cfg_wr
);

  localparam int DW     = PROD_W + FRACTION_BITS;
  localparam int MSHIFT = 30 - GUARD_BITS;

  state_t state_r, state_nxt;

  logic [REG_W-1:0]     cut_aa_r, cut_ab_r, cut_bb_r, mass_a_r, mass_b_r;
  logic [REG_W-1:0]     ax_r, ay_r, az_r, h_r, m_r;
  logic [REG_W-1:0]     ax_nxt, ay_nxt, az_nxt, h_nxt, m_nxt;
  logic                 last_r, pv_r, last_nxt, pv_nxt;
  logic [PROD_W-1:0]    rsq_r, rsq_nxt;
  logic [PROD_W-1:0]    prod_r;
  logic [REG_W-1:0]     mul_a, mul_b;
  logic [REG_W-1:0]     r_r, r_nxt, t_r, t_nxt, s_r, s_nxt;
  logic [X_W-1:0]       x_r, x_nxt;
  logic [DENSITY_W-1:0] term_r, term_nxt;
  logic [DENSITY_W-1:0] acc_r, acc_nxt;
  logic                 sticky_r, sticky_nxt;
  logic [1:0]           xcnt_r, xcnt_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [DENSITY_W-1:0] odens_r, odens_nxt;
  logic                 osat_r, osat_nxt;

  logic                 in_acc;
  logic                 ct, nt;
  logic [REG_W-1:0]     h_sel;
  logic                 div_start, sqrt_start, div_done, sqrt_done;
  logic [DW-1:0]        div_dividend, div_quot;
  logic [REG_W-1:0]     sqrt_root;
  logic [DENSITY_W:0]   acc_sum;
  logic                 atom_end;

  function automatic logic [REG_W-1:0] magnitude(input logic [REG_W-1:0] v);
    magnitude = v[REG_W-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_acc        = in_pair.valid && in_pair.ready;
  assign in_pair.ready = (state_r == ST_IDLE);
  assign cfg_wr.ready  = 1'b1;

  // type decode and cutoff pick
  always_comb begin
    ct = (TYPE_COUNT > 1) ? in_pair.center_type : 1'b0;
    nt = (TYPE_COUNT > 1) ? in_pair.neighbor_type : 1'b0;
    if (ct != nt) begin
      h_sel = cut_ab_r;
    end else if (!ct) begin
      h_sel = cut_aa_r;
    end else begin
      h_sel = cut_bb_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_aa_r <= REG_RESET_ONE;
      cut_ab_r <= REG_RESET_ONE;
      cut_bb_r <= REG_RESET_ONE;
      mass_a_r <= REG_RESET_ONE;
      mass_b_r <= REG_RESET_ONE;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_CUT_AA: cut_aa_r <= cfg_wr.data;
        CFG_CUT_AB: cut_ab_r <= cfg_wr.data;
        CFG_CUT_BB: cut_bb_r <= cfg_wr.data;
        CFG_MASS_A: mass_a_r <= cfg_wr.data;
        CFG_MASS_B: mass_b_r <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_SQX:  begin mul_a = ax_r;                mul_b = ax_r;         end
      ST_SQY:  begin mul_a = ay_r;                mul_b = ay_r;         end
      ST_SQZ:  begin mul_a = az_r;                mul_b = az_r;         end
      ST_HH:   begin mul_a = h_r;                 mul_b = h_r;          end
      ST_MT2:  begin mul_a = t_r;                 mul_b = t_r;          end
      ST_MT3:  begin mul_a = prod_r[62:31];       mul_b = t_r;          end
      ST_MP:   begin mul_a = s_r;                 mul_b = prod_r[62:31]; end
      ST_MK:   begin mul_a = prod_r[61:30];       mul_b = KERNEL_CONST; end
      ST_MM:   begin mul_a = prod_r[62:31];       mul_b = m_r;          end
      default: begin mul_a = '0;                  mul_b = '0;           end
    endcase
  end

  // registered multiplier
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  sld_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (rsq_r),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  sld_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (h_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    ax_nxt       = ax_r;
    ay_nxt       = ay_r;
    az_nxt       = az_r;
    h_nxt        = h_r;
    m_nxt        = m_r;
    last_nxt     = last_r;
    pv_nxt       = pv_r;
    rsq_nxt      = rsq_r;
    r_nxt        = r_r;
    t_nxt        = t_r;
    s_nxt        = s_r;
    x_nxt        = x_r;
    term_nxt     = term_r;
    acc_nxt      = acc_r;
    sticky_nxt   = sticky_r;
    xcnt_nxt     = xcnt_r;
    ovalid_nxt   = ovalid_r && !out_dens.ready;
    odens_nxt    = odens_r;
    osat_nxt     = osat_r;
    sqrt_start   = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    acc_sum      = {1'b0, acc_r} + {1'b0, term_r};
    atom_end     = last_r || !pv_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ax_nxt    = magnitude(in_pair.delta_x);
          ay_nxt    = magnitude(in_pair.delta_y);
          az_nxt    = magnitude(in_pair.delta_z);
          h_nxt     = h_sel;
          m_nxt     = nt ? mass_b_r : mass_a_r;
          last_nxt  = in_pair.last_neighbor;
          pv_nxt    = in_pair.pair_valid;
          state_nxt = in_pair.pair_valid ? ST_SQX : ST_FIN;
        end
      end
      ST_SQX: state_nxt = ST_SQY;
      ST_SQY: begin
        rsq_nxt   = prod_r;
        state_nxt = ST_SQZ;
      end
      ST_SQZ: begin
        rsq_nxt   = rsq_r + prod_r;
        state_nxt = ST_HH;
      end
      ST_HH: begin
        rsq_nxt   = rsq_r + prod_r;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if ((h_r != '0) && (rsq_r < prod_r)) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_SQRT;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          r_nxt     = sqrt_root;
          state_nxt = ST_TGO;
        end
      end
      // t = (h - r) * 2^31 / h
      ST_TGO: begin
        div_start    = 1'b1;
        div_dividend = DW'({(h_r - r_r), 31'd0});
        state_nxt    = ST_TWAIT;
      end
      ST_TWAIT: begin
        if (div_done) begin
          t_nxt     = div_quot[REG_W-1:0];
          state_nxt = ST_SGO;
        end
      end
      // s = (h + 3r) * 2^30 / h
      ST_SGO: begin
        div_start    = 1'b1;
        div_dividend = DW'({(34'(h_r) + 34'(r_r) + {1'b0, r_r, 1'b0}), 30'd0});
        state_nxt    = ST_SWAIT;
      end
      ST_SWAIT: begin
        if (div_done) begin
          s_nxt     = div_quot[REG_W-1:0];
          state_nxt = ST_MT2;
        end
      end
      ST_MT2: state_nxt = ST_MT3;
      ST_MT3: state_nxt = ST_MP;
      ST_MP:  state_nxt = ST_MK;
      ST_MK:  state_nxt = ST_MM;
      ST_MM:  state_nxt = ST_XLOAD;
      ST_XLOAD: begin
        x_nxt     = X_W'(prod_r[PROD_W-1:MSHIFT]);
        xcnt_nxt  = '0;
        state_nxt = ST_XGO;
      end
      // three scalings by 2^F / h
      ST_XGO: begin
        div_start    = 1'b1;
        div_dividend = DW'({x_r, {FRACTION_BITS{1'b0}}});
        state_nxt    = ST_XWAIT;
      end
      ST_XWAIT: begin
        if (div_done) begin
          if (div_quot[DW-1:X_W] != '0) begin
            term_nxt   = DENSITY_MAX;
            sticky_nxt = 1'b1;
            state_nxt  = ST_ACC;
          end else begin
            x_nxt = div_quot[X_W-1:0];
            if (xcnt_r == 2'd2) begin
              term_nxt  = div_quot[X_W-1:GUARD_BITS];
              state_nxt = ST_ACC;
            end else begin
              xcnt_nxt  = xcnt_r + 1'b1;
              state_nxt = ST_XGO;
            end
          end
        end
      end
      ST_ACC: begin
        if (acc_sum[DENSITY_W]) begin
          acc_nxt    = DENSITY_MAX;
          sticky_nxt = 1'b1;
        end else begin
          acc_nxt = acc_sum[DENSITY_W-1:0];
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!atom_end) begin
          state_nxt = ST_IDLE;
        end else if (!ovalid_r || out_dens.ready) begin
          ovalid_nxt = 1'b1;
          odens_nxt  = acc_r;
          osat_nxt   = sticky_r;
          acc_nxt    = '0;
          sticky_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      acc_r    <= '0;
      sticky_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_r    <= acc_nxt;
      sticky_r <= sticky_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    az_r   <= az_nxt;
    h_r    <= h_nxt;
    m_r    <= m_nxt;
    last_r <= last_nxt;
    pv_r   <= pv_nxt;
    rsq_r  <= rsq_nxt;
    r_r    <= r_nxt;
    t_r    <= t_nxt;
    s_r    <= s_nxt;
    x_r    <= x_nxt;
    term_r <= term_nxt;
    xcnt_r <= xcnt_nxt;
    odens_r <= odens_nxt;
    osat_r  <= osat_nxt;
  end

  assign out_dens.valid             = ovalid_r;
  assign out_dens.density           = odens_r;
  assign out_dens.density_saturated = osat_r;

endmodule

[src/sld_checker.sv]
module sld_checker import sld_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [DENSITY_W-1:0] density,
  input logic                 density_saturated
);

  // a request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after a request");

  // a clamped result always shows the full-scale density
  a_sat_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && density_saturated) |-> (density == DENSITY_MAX))
    else $error("saturation flag with density below full scale");

  // no result out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(density)
                                   && $stable(density_saturated)))
    else $error("stalled result changed");

endmodule

bind sph_lucy_density_sum_top sld_checker u_sld_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_pair.valid),
  .in_ready          (in_pair.ready),
  .out_valid         (out_dens.valid),
  .out_ready         (out_dens.ready),
  .density           (out_dens.density),
  .density_saturated (out_dens.density_saturated)
);

[tb/sph_lucy_density_sum_top_test.sv]
module sph_lucy_density_sum_top_test;
  import sld_pkg::*;

  localparam int  LONG_HOLD   = 3000;
  localparam int  DRAIN_WAIT  = 600;
  localparam longint LIMIT    = 6000000;

  typedef struct {
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [DELTA_W-1:0] dz;
    bit                        ct;
    bit                        nt;
    bit                        pv;
    bit                        last;
  } pair_req_t;

  typedef struct {
    bit [DENSITY_W-1:0] density;
    bit                 saturated;
  } density_res_t;

  logic clk;
  logic rst_n;

  sld_in_if  in_pair ();
  sld_out_if out_dens ();
  sld_cfg_if cfg_wr ();

  sph_lucy_density_sum_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pair  (in_pair),
    .out_dens (out_dens),
    .cfg_wr   (cfg_wr)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  pair_req_t    pending_pairs[$];
  density_res_t expected_densities[$];
  pair_req_t    cur_pair;

  // register copies and density state
  bit [63:0] cut_aa, cut_ab, cut_bb, mass_a, mass_b;
  bit [63:0] dens_sum;
  bit        dens_clamped;

  int  send_idle_pct;
  int  recv_stall_pct;
  bit  hold_armed;
  bit  hold_done;
  int  hold_count;
  int  error_count;
  longint cycle_count;

  function automatic bit [63:0] abs32(logic signed [DELTA_W-1:0] v);
    bit [63:0] u;
    u = {32'b0, v};
    if (u[31]) u = ({32'b0, ~v} + 64'd1) & 64'hFFFF_FFFF;
    return u;
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // floor(x * 2^frac / h), capped at 2^63
  function automatic bit [63:0] frac_scale(bit [63:0] x, bit [63:0] h, inout bit sat);
    bit [63:0] q;
    bit [63:0] rem;
    bit [63:0] cap;
    cap = 64'h8000_0000_0000_0000;
    if (h == 0) begin
      sat = 1'b1;
      return cap;
    end
    q = x / h;
    rem = x % h;
    if (q >= cap) begin
      sat = 1'b1;
      return cap;
    end
    for (int i = 0; i < FRACTION_BITS_DEF; i++) begin
      if (q >= (cap >> 1)) begin
        sat = 1'b1;
        return cap;
      end
      q = q << 1;
      rem = rem << 1;
      if (rem >= h) begin
        rem = rem - h;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic bit [63:0] lucy_term(bit [63:0] h, bit [63:0] r, bit [63:0] m,
                                          inout bit sat);
    bit [63:0] t, s, t2, t3, p, kw, x;
    t  = ((h - r) << 31) / h;
    s  = ((h + 64'd3 * r) << 30) / h;
    t2 = (t * t) >> 31;
    t3 = (t2 * t) >> 31;
    p  = (s * t3) >> 30;
    kw = (p * {32'b0, KERNEL_CONST}) >> 31;
    x  = (kw * m) >> (30 - GUARD_BITS);
    for (int k = 0; k < 3; k++) begin
      x = frac_scale(x, h, sat);
      if (sat) return {24'b0, DENSITY_MAX};
    end
    return x >> GUARD_BITS;
  endfunction

  function automatic bit [63:0] cutoff_of(bit ct, bit nt);
    if (ct != nt) return cut_ab;
    return ct ? cut_bb : cut_aa;
  endfunction

  // fold one accepted pair into the density sum
  task automatic accumulate_pair(pair_req_t p);
    bit [63:0] ax, ay, az, rsq, h, m, term, dmax;
    bit        sat;
    density_res_t res;
    dmax = {24'b0, DENSITY_MAX};
    if (p.pv) begin
      ax = abs32(p.dx);
      ay = abs32(p.dy);
      az = abs32(p.dz);
      rsq = ax * ax + ay * ay + az * az;
      h = cutoff_of(p.ct, p.nt);
      m = p.nt ? mass_b : mass_a;
      if (h != 0 && rsq < h * h) begin
        sat = 1'b0;
        term = lucy_term(h, int_sqrt(rsq), m, sat);
        if (sat) dens_clamped = 1'b1;
        if (term > dmax - dens_sum) begin
          dens_sum = dmax;
          dens_clamped = 1'b1;
        end else begin
          dens_sum = dens_sum + term;
        end
      end
    end
    if (p.last || !p.pv) begin
      res.density = dens_sum[DENSITY_W-1:0];
      res.saturated = dens_clamped;
      expected_densities.push_back(res);
      dens_sum = 0;
      dens_clamped = 1'b0;
    end
  endtask

  // pair driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_pair.valid <= 1'b0;
    end else begin
      if (in_pair.valid && in_pair.ready) accumulate_pair(cur_pair);
      if (!in_pair.valid || in_pair.ready) begin
        if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_pair = pending_pairs.pop_front();
          in_pair.valid         <= 1'b1;
          in_pair.delta_x       <= cur_pair.dx;
          in_pair.delta_y       <= cur_pair.dy;
          in_pair.delta_z       <= cur_pair.dz;
          in_pair.center_type   <= cur_pair.ct;
          in_pair.neighbor_type <= cur_pair.nt;
          in_pair.pair_valid    <= cur_pair.pv;
          in_pair.last_neighbor <= cur_pair.last;
        end else begin
          in_pair.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_armed && !hold_done) begin
      hold_count <= hold_count + 1;
      if (hold_count >= LONG_HOLD) hold_done <= 1'b1;
    end
  end

  // density monitor
  always @(posedge clk) begin
    density_res_t want;
    if (!rst_n) begin
      out_dens.ready <= 1'b0;
    end else begin
      if (out_dens.valid && out_dens.ready) begin
        if (expected_densities.size() == 0) begin
          $error("unexpected density result %0h", out_dens.density);
          error_count++;
        end else begin
          want = expected_densities.pop_front();
          if (out_dens.density !== want.density) begin
            $error("density: expected %0h actual %0h", want.density, out_dens.density);
            error_count++;
          end
          if (out_dens.density_saturated !== want.saturated) begin
            $error("density_saturated: expected %0b actual %0b", want.saturated,
                   out_dens.density_saturated);
            error_count++;
          end
        end
      end
      out_dens.ready <= !(hold_armed && !hold_done) &&
                        ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (pending_pairs.size() != 0 || in_pair.valid || expected_densities.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, bit [REG_W-1:0] value);
    @(posedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= value;
    do @(posedge clk); while (!(cfg_wr.valid && cfg_wr.ready));
    cfg_wr.valid <= 1'b0;
    case (idx)
      CFG_CUT_AA: cut_aa = value;
      CFG_CUT_AB: cut_ab = value;
      CFG_CUT_BB: cut_bb = value;
      CFG_MASS_A: mass_a = value;
      CFG_MASS_B: mass_b = value;
      default: ;
    endcase
  endtask

  // new register set once the block has drained
  task automatic set_regs(bit [31:0] aa, bit [31:0] ab, bit [31:0] bb,
                          bit [31:0] ma, bit [31:0] mb);
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    write_reg(CFG_CUT_AA, aa);
    write_reg(CFG_CUT_AB, ab);
    write_reg(CFG_CUT_BB, bb);
    write_reg(CFG_MASS_A, ma);
    write_reg(CFG_MASS_B, mb);
  endtask

  task automatic push_pair(logic signed [31:0] dx, logic signed [31:0] dy,
                           logic signed [31:0] dz, bit ct, bit nt, bit pv, bit last);
    pair_req_t p;
    p.dx = dx;
    p.dy = dy;
    p.dz = dz;
    p.ct = ct;
    p.nt = nt;
    p.pv = pv;
    p.last = last;
    pending_pairs.push_back(p);
  endtask

  // mostly within half the cutoff per axis, sometimes anything
  function automatic logic signed [31:0] pick_delta(bit [63:0] h);
    bit [31:0] mag;
    if ($urandom_range(99) < 25) return $urandom;
    mag = $urandom_range(0, h[32:1]);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  // random atoms: neighbor lists, empty atoms, and broken lists
  task automatic add_atoms(int n_items);
    int  pushed;
    int  len;
    bit  ct;
    bit  nt;
    bit  brk;
    bit [63:0] h;
    pushed = 0;
    while (pushed < n_items) begin
      if ($urandom_range(99) < 8) begin
        push_pair($urandom, $urandom, $urandom, $urandom_range(1), $urandom_range(1),
                  1'b0, $urandom_range(1));
        pushed++;
      end else begin
        len = $urandom_range(1, 6);
        ct = $urandom_range(1);
        for (int i = 0; i < len; i++) begin
          nt = $urandom_range(1);
          h = cutoff_of(ct, nt);
          brk = ($urandom_range(99) < 5);
          push_pair(pick_delta(h), pick_delta(h), pick_delta(h), ct, nt, !brk,
                    (i == len - 1) || ($urandom_range(99) < 3));
          pushed++;
        end
      end
    end
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n_items, bit long_hold);
    wait_idle();
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold) hold_armed = 1'b1;
    add_atoms(n_items);
  endtask

  initial begin
    rst_n = 1'b0;
    in_pair.valid = 1'b0;
    in_pair.delta_x = '0;
    in_pair.delta_y = '0;
    in_pair.delta_z = '0;
    in_pair.center_type = 1'b0;
    in_pair.neighbor_type = 1'b0;
    in_pair.pair_valid = 1'b0;
    in_pair.last_neighbor = 1'b0;
    out_dens.ready = 1'b0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = CFG_CUT_AA;
    cfg_wr.data = '0;
    cut_aa = REG_RESET_ONE;
    cut_ab = REG_RESET_ONE;
    cut_bb = REG_RESET_ONE;
    mass_a = REG_RESET_ONE;
    mass_b = REG_RESET_ONE;
    dens_sum = 0;
    dens_clamped = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_armed = 1'b0;
    hold_done = 1'b0;
    hold_count = 0;
    error_count = 0;
    cycle_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed pairs at reset cutoffs of 1.0
    push_pair(0, 0, 0, 0, 0, 1, 0);                        // zero distance
    push_pair(32'sh8000, 0, 0, 0, 1, 1, 0);                // mixed pair, half cutoff
    push_pair(0, -32'sh4000, 32'sh2000, 0, 0, 1, 1);       // end of atom
    push_pair(32'sh0000_FFFF, 0, 0, 1, 1, 1, 1);           // just inside
    push_pair(32'sh0001_0000, 0, 0, 1, 0, 1, 1);           // exactly on the cutoff
    push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 1, 0);
    push_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1, 1);
    push_pair(0, 0, 0, 0, 0, 0, 0);                        // empty atom
    push_pair(32'sh1000, 32'sh1000, 0, 1, 0, 1, 0);
    push_pair(32'h8000_0000, 0, 0, 1, 1, 0, 1);            // not-valid ends busy atom
    push_pair(-32'sh1, 32'sh1, -32'sh1, 0, 1, 1, 0);
    push_pair(32'sh3000, 0, 0, 0, 0, 1, 0);
    push_pair(0, 32'sh7000, 0, 0, 1, 1, 1);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0, 1);

    // saturation at the largest cutoffs and masses
    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(0, 0, 0, 0, 0, 1, 1);
    push_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 1, 1, 1);
    push_pair(32'h4000_0000, 0, 0, 0, 1, 1, 1);
    run_phase(50, 0, 250, 1'b0);

    set_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000);
    run_phase(0, 0, 300, 1'b1);

    // smallest cutoffs, zero masses
    set_regs(32'd1, 32'd1, 32'd1, 32'd0, 32'd0);
    push_pair(0, 0, 0, 0, 1, 1, 1);
    run_phase(0, 50, 200, 1'b0);

    set_regs(32'h0010_0000, 32'h0001_8000, 32'h0002_0000, $urandom, $urandom_range(1 << 20));
    run_phase(26, 26, 350, 1'b0);

    set_regs($urandom_range(32'h0100_0000, 32'h1000), $urandom_range(32'h0100_0000, 32'h1000),
             $urandom_range(32'h0100_0000, 32'h1000), $urandom_range(1 << 24),
             $urandom_range(1 << 24));
    run_phase(0, 0, 350, 1'b0);

    set_regs($urandom_range(32'hFFFF_FFFF, 1), $urandom_range(32'hFFFF_FFFF, 1),
             $urandom_range(32'hFFFF_FFFF, 1), $urandom, $urandom);
    run_phase(26, 26, 350, 1'b0);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
src/sld_pkg.sv
src/sld_if.sv
src/sld_div.sv
src/sld_sqrt.sv
src/sph_lucy_density_sum_top.sv
src/sld_checker.sv
tb/sph_lucy_density_sum_top_test.sv
